[hdl/wpc_pkg.sv]
// shared constants and control types for the waypoint pd command step
package wpc_pkg;

    localparam int CFG_W = 32;
    localparam int IDX_W = 3;
    localparam int GAIN_W = 16;

    localparam logic [IDX_W-1:0] REG_GAINS_X         = 3'd0;
    localparam logic [IDX_W-1:0] REG_GAINS_Y         = 3'd1;
    localparam logic [IDX_W-1:0] REG_GAINS_Z         = 3'd2;
    localparam logic [IDX_W-1:0] REG_GAINS_YAW       = 3'd3;
    localparam logic [IDX_W-1:0] REG_UNIT_STEP       = 3'd4;
    localparam logic [IDX_W-1:0] REG_GOAL_RADIUS     = 3'd5;
    localparam logic [IDX_W-1:0] REG_TARGET_ALTITUDE = 3'd6;
    localparam logic [IDX_W-1:0] REG_TARGET_HEADING  = 3'd7;

    localparam int OBS_W = 3;
    localparam logic [OBS_W-1:0] OBS_CLEAR = 3'd0;
    localparam logic [OBS_W-1:0] OBS_LEFT  = 3'd2;
    localparam logic [OBS_W-1:0] OBS_RIGHT = 3'd3;
    localparam logic [OBS_W-1:0] OBS_LAND  = 3'd5;

    localparam int ALT_RESET  = 1229;
    localparam int TERM_SHIFT = 8;
    localparam int ALT_SHIFT  = 10;
    localparam int PCT_SCALE  = 100;
    localparam int KEEP_PCT   = 33;

    localparam int CNT_W = 6;
    localparam logic [CNT_W-1:0] CNT_MAX = 6'd63;

    typedef struct packed {
        logic load;
        logic term;
        logic maxm;
        logic prep;
        logic ovf;
        logic step;
        logic alt;
    } wpc_ctrl_t;

endpackage

[hdl/wpc_in_if.sv]
// input channel: one control tick of measurements and waypoint
interface wpc_in_if #(parameter int DW = 16);
    logic                 valid;
    logic                 ready;
    logic signed [DW-1:0] pos_x;
    logic signed [DW-1:0] pos_y;
    logic signed [DW-1:0] pos_z;
    logic signed [DW-1:0] heading;
    logic signed [DW-1:0] vel_x;
    logic signed [DW-1:0] vel_y;
    logic signed [DW-1:0] vel_z;
    logic signed [DW-1:0] vel_heading;
    logic signed [DW-1:0] goal_x;
    logic signed [DW-1:0] goal_y;
    logic [2:0]           obstacle_code;
    logic                 link_lost;

    modport source (
        output valid, pos_x, pos_y, pos_z, heading, vel_x, vel_y, vel_z, vel_heading,
               goal_x, goal_y, obstacle_code, link_lost,
        input  ready
    );
    modport sink (
        input  valid, pos_x, pos_y, pos_z, heading, vel_x, vel_y, vel_z, vel_heading,
               goal_x, goal_y, obstacle_code, link_lost,
        output ready
    );
endinterface

[hdl/wpc_out_if.sv]
// output channel: one command result per tick
interface wpc_out_if #(parameter int DW = 16);
    logic                 valid;
    logic                 ready;
    logic signed [DW-1:0] cmd_roll;
    logic signed [DW-1:0] cmd_pitch;
    logic signed [DW-1:0] cmd_climb;
    logic signed [DW-1:0] cmd_turn;
    logic                 advance;
    logic                 land_request;
    logic                 settled;

    modport source (
        output valid, cmd_roll, cmd_pitch, cmd_climb, cmd_turn, advance, land_request,
               settled,
        input  ready
    );
    modport sink (
        input  valid, cmd_roll, cmd_pitch, cmd_climb, cmd_turn, advance, land_request,
               settled,
        output ready
    );
endinterface

[hdl/wpc_lane.sv]
// one axis lane: pd term and its scaling by a bit-serial divider
module wpc_lane #(
    parameter int DW = 16
) (
    input  logic                  clk,
    input  wpc_pkg::wpc_ctrl_t    ctrl,
    input  logic signed [DW-1:0]  setp,
    input  logic signed [DW-1:0]  meas,
    input  logic signed [DW-1:0]  vel,
    input  logic [wpc_pkg::CFG_W-1:0] gains,
    input  logic [DW+9:0]         m,
    input  logic [DW-2:0]         u,
    output logic signed [DW+9:0]  term,
    output logic signed [DW:0]    err,
    output logic signed [DW-1:0]  cmd
);
    import wpc_pkg::*;

    localparam int EW = DW + 1;
    localparam int PW = DW + 18;
    localparam int TW = DW + 10;
    localparam int AW = TW + 7;
    localparam int NW = TW + DW - 1;
    localparam int QW = DW - 1;
    localparam logic signed [DW-1:0] CMD_HI = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] CMD_LO = {1'b1, {(DW-1){1'b0}}};

    logic [GAIN_W-1:0]     kp;
    logic [GAIN_W-1:0]     kd;
    logic signed [EW-1:0]  e;
    logic signed [PW-1:0]  kp_s;
    logic signed [PW-1:0]  kd_s;
    logic signed [PW-1:0]  e_s;
    logic signed [PW-1:0]  v_s;
    logic signed [PW-1:0]  diff;
    logic signed [PW-1:0]  diff_sh;
    logic [TW-1:0]         a;
    logic [AW-1:0]         a_pct;
    logic [AW-1:0]         m_pct;
    logic [TW-1:0]         n_hi;
    logic [TW:0]           trial;
    logic                  ge;

    logic signed [EW-1:0]  err_reg;
    logic signed [PW-1:0]  pe_reg;
    logic signed [PW-1:0]  dv_reg;
    logic signed [TW-1:0]  t_reg;
    logic [NW-1:0]         n_reg;
    logic [TW-1:0]         rem_reg;
    logic [QW-1:0]         nlo_reg;
    logic [QW-1:0]         q_reg;
    logic                  mzero_reg;
    logic                  tzero_reg;
    logic                  neg_reg;
    logic                  kill_reg;
    logic                  cap_reg;

    assign kp = gains[CFG_W-1 -: GAIN_W];
    assign kd = gains[GAIN_W-1:0];
    assign e  = EW'(setp) - EW'(meas);

    assign kp_s = PW'($signed({1'b0, kp}));
    assign kd_s = PW'($signed({1'b0, kd}));
    assign e_s  = PW'(e);
    assign v_s  = PW'(vel);

    assign diff    = pe_reg - dv_reg;
    assign diff_sh = diff >>> TERM_SHIFT;

    assign a     = t_reg[TW-1] ? TW'(0) - $unsigned(t_reg) : $unsigned(t_reg);
    assign a_pct = AW'(a) * AW'(PCT_SCALE);
    assign m_pct = AW'(m) * AW'(KEEP_PCT);

    // quotient is floor(|t| * u / m); the product's top TW bits seed the remainder
    assign n_hi  = n_reg[NW-1 -: TW];
    assign trial = {rem_reg, nlo_reg[QW-1]};
    assign ge    = trial >= {1'b0, m};

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            err_reg <= e;
            pe_reg  <= kp_s * e_s;
            dv_reg  <= kd_s * v_s;
        end
        if (ctrl.term)
            t_reg <= diff_sh[TW-1:0];
        if (ctrl.prep)
        begin
            n_reg     <= NW'(a) * NW'(u);
            mzero_reg <= (m == '0);
            tzero_reg <= (t_reg == '0);
            neg_reg   <= t_reg[TW-1];
            kill_reg  <= (a_pct < m_pct);
        end
        if (ctrl.ovf)
        begin
            cap_reg <= (n_hi >= m);
            rem_reg <= n_hi;
            nlo_reg <= n_reg[QW-1:0];
            q_reg   <= '0;
        end
        if (ctrl.step)
        begin
            rem_reg <= ge ? TW'(trial - {1'b0, m}) : trial[TW-1:0];
            nlo_reg <= nlo_reg << 1;
            q_reg   <= {q_reg[QW-2:0], ge};
        end
    end

    always_comb
    begin
        if (mzero_reg)
            cmd = tzero_reg ? '0 : (neg_reg ? CMD_LO : CMD_HI);
        else if (kill_reg)
            cmd = '0;
        else if (cap_reg)
            cmd = neg_reg ? CMD_LO : CMD_HI;
        else
            cmd = neg_reg ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg});
    end

    assign term = t_reg;
    assign err  = err_reg;

endmodule

[hdl/wpc_merge.sv]
// merge stage: largest term, reach test, yaw and altitude shaping, overrides
module wpc_merge #(
    parameter int DW = 16,
    parameter int YAW_DEADBAND = 179
) (
    input  logic                  clk,
    input  wpc_pkg::wpc_ctrl_t    ctrl,
    input  logic signed [DW+9:0]  term_x,
    input  logic signed [DW+9:0]  term_y,
    input  logic signed [DW+9:0]  term_z,
    input  logic signed [DW+9:0]  term_yaw,
    input  logic signed [DW:0]    err_x,
    input  logic signed [DW:0]    err_y,
    input  logic signed [DW:0]    err_yaw,
    input  logic signed [DW-1:0]  lane_roll,
    input  logic signed [DW-1:0]  lane_pitch,
    input  logic signed [DW-1:0]  lane_climb,
    input  logic signed [DW-1:0]  lane_turn,
    input  logic [DW-2:0]         u,
    input  logic [DW-2:0]         radius,
    input  logic [wpc_pkg::OBS_W-1:0] obstacle,
    input  logic                  lost,
    input  logic                  latch,
    output logic [DW+9:0]         m,
    output logic signed [DW-1:0]  roll,
    output logic signed [DW-1:0]  pitch,
    output logic signed [DW-1:0]  climb,
    output logic signed [DW-1:0]  turn,
    output logic                  land,
    output logic                  settled
);
    import wpc_pkg::*;

    localparam int EW = DW + 1;
    localparam int TW = DW + 10;
    localparam int SW = 2 * DW - 2;
    localparam int XW = 2 * DW;
    localparam logic signed [DW-1:0] CMD_HI = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] CMD_LO = {1'b1, {(DW-1){1'b0}}};

    logic signed [TW-1:0] mx_a;
    logic signed [TW-1:0] mx_b;
    logic signed [TW-1:0] mx;
    logic [EW-1:0]        ax;
    logic [EW-1:0]        ay;
    logic [EW-1:0]        ayaw;
    logic [SW:0]          sq_sum;
    logic                 reached;
    logic signed [XW-1:0] alt_sh;
    logic signed [DW-1:0] alt_sat;
    logic signed [DW-1:0] u_s;
    logic signed [DW-1:0] yaw_cmd;
    logic                 zero_all;

    logic [TW-1:0]        m_reg;
    logic [SW-1:0]        sqx_reg;
    logic [SW-1:0]        sqy_reg;
    logic [SW-1:0]        rr_reg;
    logic                 prex_reg;
    logic                 prey_reg;
    logic signed [XW-1:0] alt_prod_reg;

    assign mx_a = (term_y > term_x) ? term_y : term_x;
    assign mx_b = (term_yaw > term_z) ? term_yaw : term_z;
    assign mx   = (mx_b > mx_a) ? mx_b : mx_a;

    assign ax   = err_x[EW-1] ? EW'(0) - $unsigned(err_x) : $unsigned(err_x);
    assign ay   = err_y[EW-1] ? EW'(0) - $unsigned(err_y) : $unsigned(err_y);
    assign ayaw = err_yaw[EW-1] ? EW'(0) - $unsigned(err_yaw) : $unsigned(err_yaw);

    assign u_s = $signed({1'b0, u});

    always_ff @(posedge clk)
    begin
        if (ctrl.maxm)
            m_reg <= mx[TW-1] ? TW'(0) - $unsigned(mx) : $unsigned(mx);
        // reach test squares only matter when both per-axis checks pass
        prex_reg <= ax < EW'(radius);
        prey_reg <= ay < EW'(radius);
        sqx_reg  <= SW'(ax[DW-2:0]) * SW'(ax[DW-2:0]);
        sqy_reg  <= SW'(ay[DW-2:0]) * SW'(ay[DW-2:0]);
        rr_reg   <= SW'(radius) * SW'(radius);
        if (ctrl.alt)
            alt_prod_reg <= XW'(lane_climb) * XW'(u_s);
    end

    assign sq_sum  = (SW+1)'(sqx_reg) + (SW+1)'(sqy_reg);
    assign reached = prex_reg && prey_reg && (sq_sum < (SW+1)'(rr_reg));
    assign settled = reached || latch;

    assign alt_sh = alt_prod_reg >>> ALT_SHIFT;

    always_comb
    begin
        if ((alt_sh[XW-1:DW-1] == '0) || (alt_sh[XW-1:DW-1] == '1))
            alt_sat = alt_sh[DW-1:0];
        else
            alt_sat = alt_sh[XW-1] ? CMD_LO : CMD_HI;
    end

    always_comb
    begin
        if (ayaw < EW'(YAW_DEADBAND))
            yaw_cmd = '0;
        else if (err_yaw != '0)
            yaw_cmd = err_yaw[EW-1] ? -u_s : u_s;
        else
            yaw_cmd = lane_turn;
    end

    assign zero_all = settled || (obstacle != OBS_CLEAR) || lost;

    always_comb
    begin
        pitch = zero_all ? '0 : lane_pitch;
        climb = zero_all ? '0 : alt_sat;
        turn  = zero_all ? '0 : yaw_cmd;
        case (obstacle)
            OBS_LEFT:  roll = u_s;
            OBS_RIGHT: roll = -u_s;
            default:   roll = zero_all ? '0 : lane_roll;
        endcase
    end

    assign land = (obstacle == OBS_LAND);
    assign m    = m_reg;

endmodule

[hdl/waypoint_pd_command_step.sv]
// top level of the waypoint pd command step
//
//  channel  | dir  | handshake     | beat
//  ---------+------+---------------+----------------------------------------------
//  tick     | in   | valid/ready   | pose, velocities, waypoint, obstacle, link
//  cmd      | out  | valid/ready   | roll, pitch, climb, turn, advance, land, settled
//  cfg      | in   | write enable  | register index and data
//
// a tick steps through the term, max, prep, overflow, divide, altitude and final states
// before the next acceptance; the lane dividers find one quotient bit per cycle.
// an advance tick goes from idle straight to the final state.
// reset clears the settle latch, the counter and the registers to their defaults.
// a result held in the output register does not block the next tick; a second
// result waits in the final state until the first beat is taken.
module waypoint_pd_command_step #(
    parameter int HOLD_TICKS   = 30,
    parameter int YAW_DEADBAND = 179,
    parameter int DATA_WIDTH   = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [wpc_pkg::IDX_W-1:0] cfg_index,
    input  logic [wpc_pkg::CFG_W-1:0] cfg_data,
    wpc_in_if.sink                    tick,
    wpc_out_if.source                 cmd
);
    import wpc_pkg::*;

    localparam int DW = DATA_WIDTH;
    localparam int EW = DW + 1;
    localparam int TW = DW + 10;
    localparam int QW = DW - 1;
    localparam int CW = $clog2(QW);

    typedef enum logic [2:0] {
        S_IDLE,
        S_TERM,
        S_MAX,
        S_PREP,
        S_OVF,
        S_DIV,
        S_ALT,
        S_FIN
    } state_t;

    logic [CFG_W-1:0]     gains_x_reg;
    logic [CFG_W-1:0]     gains_y_reg;
    logic [CFG_W-1:0]     gains_z_reg;
    logic [CFG_W-1:0]     gains_yaw_reg;
    logic [DW-2:0]        unit_step_reg;
    logic [DW-2:0]        goal_radius_reg;
    logic signed [DW-1:0] target_altitude_reg;
    logic signed [DW-1:0] target_heading_reg;

    state_t               state_reg;
    state_t               state_next;
    logic [CW-1:0]        cnt_reg;
    logic [CW-1:0]        cnt_next;
    logic                 adv_reg;
    logic                 adv_next;
    logic                 latch_reg;
    logic                 latch_next;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic [OBS_W-1:0]     obstacle_reg;
    logic [OBS_W-1:0]     obstacle_next;
    logic                 lost_reg;
    logic                 lost_next;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic signed [DW-1:0] roll_reg;
    logic signed [DW-1:0] roll_next;
    logic signed [DW-1:0] pitch_reg;
    logic signed [DW-1:0] pitch_next;
    logic signed [DW-1:0] climb_reg;
    logic signed [DW-1:0] climb_next;
    logic signed [DW-1:0] turn_reg;
    logic signed [DW-1:0] turn_next;
    logic                 advance_reg;
    logic                 advance_next;
    logic                 land_reg;
    logic                 land_next;
    logic                 settled_reg;
    logic                 settled_next;

    logic                 accept;
    logic                 commit;
    wpc_ctrl_t            ctrl;

    logic signed [TW-1:0] term_x;
    logic signed [TW-1:0] term_y;
    logic signed [TW-1:0] term_z;
    logic signed [TW-1:0] term_yaw;
    logic signed [EW-1:0] err_x;
    logic signed [EW-1:0] err_y;
    logic signed [EW-1:0] err_z;
    logic signed [EW-1:0] err_yaw;
    logic signed [DW-1:0] lane_roll;
    logic signed [DW-1:0] lane_pitch;
    logic signed [DW-1:0] lane_climb;
    logic signed [DW-1:0] lane_turn;
    logic [TW-1:0]        m;
    logic signed [DW-1:0] mg_roll;
    logic signed [DW-1:0] mg_pitch;
    logic signed [DW-1:0] mg_climb;
    logic signed [DW-1:0] mg_turn;
    logic                 mg_land;
    logic                 mg_settled;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gains_x_reg         <= '0;
            gains_y_reg         <= '0;
            gains_z_reg         <= '0;
            gains_yaw_reg       <= '0;
            unit_step_reg       <= '0;
            goal_radius_reg     <= '0;
            target_altitude_reg <= DW'(ALT_RESET);
            target_heading_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_GAINS_X:         gains_x_reg         <= cfg_data;
                REG_GAINS_Y:         gains_y_reg         <= cfg_data;
                REG_GAINS_Z:         gains_z_reg         <= cfg_data;
                REG_GAINS_YAW:       gains_yaw_reg       <= cfg_data;
                REG_UNIT_STEP:       unit_step_reg       <= cfg_data[DW-2:0];
                REG_GOAL_RADIUS:     goal_radius_reg     <= cfg_data[DW-2:0];
                REG_TARGET_ALTITUDE: target_altitude_reg <= cfg_data[DW-1:0];
                REG_TARGET_HEADING:  target_heading_reg  <= cfg_data[DW-1:0];
                default:             ;
            endcase
        end
    end

    assign tick.ready = (state_reg == S_IDLE);
    assign accept     = tick.valid && tick.ready;
    assign commit     = (state_reg == S_FIN) && (!out_valid_reg || cmd.ready);

    always_comb
    begin
        ctrl.load = accept;
        ctrl.term = (state_reg == S_TERM);
        ctrl.maxm = (state_reg == S_MAX);
        ctrl.prep = (state_reg == S_PREP);
        ctrl.ovf  = (state_reg == S_OVF);
        ctrl.step = (state_reg == S_DIV);
        ctrl.alt  = (state_reg == S_ALT);
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        adv_next       = adv_reg;
        latch_next     = latch_reg;
        count_next     = count_reg;
        obstacle_next  = obstacle_reg;
        lost_next      = lost_reg;
        out_valid_next = out_valid_reg && !cmd.ready;
        roll_next      = roll_reg;
        pitch_next     = pitch_reg;
        climb_next     = climb_reg;
        turn_next      = turn_reg;
        advance_next   = advance_reg;
        land_next      = land_reg;
        settled_next   = settled_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    adv_next      = count_reg > CNT_W'(HOLD_TICKS);
                    obstacle_next = tick.obstacle_code;
                    lost_next     = tick.link_lost;
                    state_next    = (count_reg > CNT_W'(HOLD_TICKS)) ? S_FIN : S_TERM;
                end
            end
            S_TERM: state_next = S_MAX;
            S_MAX:  state_next = S_PREP;
            S_PREP: state_next = S_OVF;
            S_OVF:
            begin
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(QW - 1))
                    state_next = S_ALT;
            end
            S_ALT:  state_next = S_FIN;
            S_FIN:
            begin
                if (commit)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                    if (adv_reg)
                    begin
                        latch_next   = 1'b0;
                        count_next   = '0;
                        roll_next    = '0;
                        pitch_next   = '0;
                        climb_next   = '0;
                        turn_next    = '0;
                        advance_next = 1'b1;
                        land_next    = 1'b0;
                        settled_next = 1'b0;
                    end
                    else
                    begin
                        if (mg_settled)
                        begin
                            latch_next = 1'b1;
                            if (count_reg != CNT_MAX)
                                count_next = count_reg + 1'b1;
                        end
                        roll_next    = mg_roll;
                        pitch_next   = mg_pitch;
                        climb_next   = mg_climb;
                        turn_next    = mg_turn;
                        advance_next = 1'b0;
                        land_next    = mg_land;
                        settled_next = mg_settled;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            adv_reg       <= 1'b0;
            latch_reg     <= 1'b0;
            count_reg     <= '0;
            obstacle_reg  <= '0;
            lost_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            roll_reg      <= '0;
            pitch_reg     <= '0;
            climb_reg     <= '0;
            turn_reg      <= '0;
            advance_reg   <= 1'b0;
            land_reg      <= 1'b0;
            settled_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            adv_reg       <= adv_next;
            latch_reg     <= latch_next;
            count_reg     <= count_next;
            obstacle_reg  <= obstacle_next;
            lost_reg      <= lost_next;
            out_valid_reg <= out_valid_next;
            roll_reg      <= roll_next;
            pitch_reg     <= pitch_next;
            climb_reg     <= climb_next;
            turn_reg      <= turn_next;
            advance_reg   <= advance_next;
            land_reg      <= land_next;
            settled_reg   <= settled_next;
        end
    end

    wpc_lane #(.DW(DW)) u_lane_x (
        .clk   (clk),
        .ctrl  (ctrl),
        .setp  (tick.goal_x),
        .meas  (tick.pos_x),
        .vel   (tick.vel_x),
        .gains (gains_x_reg),
        .m     (m),
        .u     (unit_step_reg),
        .term  (term_x),
        .err   (err_x),
        .cmd   (lane_roll)
    );

    wpc_lane #(.DW(DW)) u_lane_y (
        .clk   (clk),
        .ctrl  (ctrl),
        .setp  (tick.goal_y),
        .meas  (tick.pos_y),
        .vel   (tick.vel_y),
        .gains (gains_y_reg),
        .m     (m),
        .u     (unit_step_reg),
        .term  (term_y),
        .err   (err_y),
        .cmd   (lane_pitch)
    );

    // altitude error is not needed downstream, only its term and its command
    wpc_lane #(.DW(DW)) u_lane_z (
        .clk   (clk),
        .ctrl  (ctrl),
        .setp  (target_altitude_reg),
        .meas  (tick.pos_z),
        .vel   (tick.vel_z),
        .gains (gains_z_reg),
        .m     (m),
        .u     (unit_step_reg),
        .term  (term_z),
        .err   (err_z),
        .cmd   (lane_climb)
    );

    wpc_lane #(.DW(DW)) u_lane_yaw (
        .clk   (clk),
        .ctrl  (ctrl),
        .setp  (target_heading_reg),
        .meas  (tick.heading),
        .vel   (tick.vel_heading),
        .gains (gains_yaw_reg),
        .m     (m),
        .u     (unit_step_reg),
        .term  (term_yaw),
        .err   (err_yaw),
        .cmd   (lane_turn)
    );

    wpc_merge #(.DW(DW), .YAW_DEADBAND(YAW_DEADBAND)) u_merge (
        .clk        (clk),
        .ctrl       (ctrl),
        .term_x     (term_x),
        .term_y     (term_y),
        .term_z     (term_z),
        .term_yaw   (term_yaw),
        .err_x      (err_x),
        .err_y      (err_y),
        .err_yaw    (err_yaw),
        .lane_roll  (lane_roll),
        .lane_pitch (lane_pitch),
        .lane_climb (lane_climb),
        .lane_turn  (lane_turn),
        .u          (unit_step_reg),
        .radius     (goal_radius_reg),
        .obstacle   (obstacle_reg),
        .lost       (lost_reg ^ (err_z[EW-1] & 1'b0)),
        .latch      (latch_reg),
        .m          (m),
        .roll       (mg_roll),
        .pitch      (mg_pitch),
        .climb      (mg_climb),
        .turn       (mg_turn),
        .land       (mg_land),
        .settled    (mg_settled)
    );

    assign cmd.valid        = out_valid_reg;
    assign cmd.cmd_roll     = roll_reg;
    assign cmd.cmd_pitch    = pitch_reg;
    assign cmd.cmd_climb    = climb_reg;
    assign cmd.cmd_turn     = turn_reg;
    assign cmd.advance      = advance_reg;
    assign cmd.land_request = land_reg;
    assign cmd.settled      = settled_reg;

endmodule

[hdl/wpc_checker.sv]
// port-level checks on the command channel, bound to the top level
module wpc_checker #(
    parameter int DW = 16
) (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 valid,
    input logic                 ready,
    input logic signed [DW-1:0] roll,
    input logic signed [DW-1:0] pitch,
    input logic signed [DW-1:0] climb,
    input logic signed [DW-1:0] turn,
    input logic                 advance,
    input logic                 land,
    input logic                 settled
);

    // an advance beat carries nothing else
    a_advance_alone: assert property (@(posedge clk) disable iff (!rst_n)
        valid && advance |-> roll == '0 && pitch == '0 && climb == '0 && turn == '0
                             && !land && !settled)
        else $error("advance beat with nonzero fields");

    // landing forces every command to zero
    a_land_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        valid && land |-> roll == '0 && pitch == '0 && climb == '0 && turn == '0)
        else $error("land request with live commands");

    // once settled only an obstacle roll may remain
    a_settled_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        valid && settled |-> pitch == '0 && climb == '0 && turn == '0)
        else $error("settled beat with live commands");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> valid && $stable(roll) && $stable(pitch) && $stable(climb)
                            && $stable(turn) && $stable(advance) && $stable(settled))
        else $error("stalled beat changed");

endmodule

bind waypoint_pd_command_step wpc_checker #(.DW(DATA_WIDTH)) u_wpc_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid   (cmd.valid),
    .ready   (cmd.ready),
    .roll    (cmd.cmd_roll),
    .pitch   (cmd.cmd_pitch),
    .climb   (cmd.cmd_climb),
    .turn    (cmd.cmd_turn),
    .advance (cmd.advance),
    .land    (cmd.land_request),
    .settled (cmd.settled)
);

[dv/waypoint_pd_command_step_checker.sv]
// checker for the waypoint pd command step: predicts each command beat and compares
`timescale 1ns / 100ps

module waypoint_pd_command_step_checker #(
    parameter int HOLD_TICKS   = 30,
    parameter int YAW_DEADBAND = 179,
    parameter int DATA_WIDTH   = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [wpc_pkg::IDX_W-1:0] cfg_index,
    input  logic [wpc_pkg::CFG_W-1:0] cfg_data,
    wpc_in_if                         tick,
    wpc_out_if                        cmd,
    output int                        errors,
    output int                        pending
);
    import wpc_pkg::*;

    typedef logic signed [DATA_WIDTH-1:0] word_t;

    typedef struct {
        word_t roll;
        word_t pitch;
        word_t climb;
        word_t turn;
        logic  advance;
        logic  land;
        logic  settled;
    } command_t;

    localparam longint WORD_HI = (64'sd1 <<< (DATA_WIDTH - 1)) - 1;
    localparam longint WORD_LO = -WORD_HI - 1;
    localparam longint STEP_LIM = 64'sd1 <<< DATA_WIDTH;

    // predictor copy of the block's registers and state
    logic [CFG_W-1:0]             gains [4];
    logic [DATA_WIDTH-2:0]        unit_step;
    logic [DATA_WIDTH-2:0]        goal_radius;
    logic signed [DATA_WIDTH-1:0] target_alt;
    logic signed [DATA_WIDTH-1:0] target_heading;
    logic                         settle_latch;
    logic [CNT_W-1:0]             settle_count;

    command_t commands_due [$];

    function automatic longint magnitude(input longint x);
        return x < 0 ? -x : x;
    endfunction

    function automatic longint clip(input longint x);
        return x > WORD_HI ? WORD_HI : (x < WORD_LO ? WORD_LO : x);
    endfunction

    // share of the largest term mapped onto the unit step
    function automatic longint scaled_share(input longint t, input longint m, input longint u);
        longint a;
        longint q;
        longint total;
        if (m == 0)
            return t == 0 ? 0 : (t < 0 ? WORD_LO : WORD_HI);
        a = magnitude(t);
        if (a * PCT_SCALE < m * KEEP_PCT)
            return 0;
        q = a / m;
        if (q >= STEP_LIM && u != 0)
            total = STEP_LIM;
        else
            total = q * u + ((a % m) * u) / m;
        if (total > STEP_LIM)
            total = STEP_LIM;
        return clip(t < 0 ? -total : total);
    endfunction

    function automatic command_t compute_command(input longint meas [4], input longint vel [4],
                                                 input longint gx, input longint gy,
                                                 input logic [OBS_W-1:0] code,
                                                 input logic lost);
        command_t r;
        longint   setp [4];
        longint   e [4];
        longint   t [4];
        longint   c [4];
        longint   kp;
        longint   kd;
        longint   mx;
        longint   m;
        longint   u;
        longint   rad;
        logic     hit;
        r = '{default: '0};
        if (settle_count > HOLD_TICKS)
        begin
            settle_latch = 1'b0;
            settle_count = '0;
            r.advance = 1'b1;
            return r;
        end
        u = unit_step;
        setp[0] = gx;
        setp[1] = gy;
        setp[2] = target_alt;
        setp[3] = target_heading;
        for (int i = 0; i < 4; i++)
        begin
            kp = gains[i][31:16];
            kd = gains[i][15:0];
            e[i] = setp[i] - meas[i];
            t[i] = (kp * e[i] - kd * vel[i]) >>> TERM_SHIFT;
        end
        mx = t[0];
        for (int i = 1; i < 4; i++)
            if (t[i] > mx)
                mx = t[i];
        m = magnitude(mx);
        for (int i = 0; i < 4; i++)
            c[i] = scaled_share(t[i], m, u);

        if (magnitude(e[3]) < YAW_DEADBAND)
            c[3] = 0;
        else if (e[3] != 0)
            c[3] = e[3] < 0 ? -u : u;
        c[2] = clip((c[2] * u) >>> ALT_SHIFT);

        rad = goal_radius;
        hit = magnitude(e[0]) < rad && magnitude(e[1]) < rad &&
              e[0] * e[0] + e[1] * e[1] < rad * rad;
        if (hit || settle_latch)
        begin
            settle_latch = 1'b1;
            if (settle_count != CNT_MAX)
                settle_count = settle_count + 1'b1;
            hit = 1'b1;
        end

        if (hit || code != OBS_CLEAR || lost)
            for (int i = 0; i < 4; i++)
                c[i] = 0;
        case (code)
            OBS_LEFT:  c[0] = u;
            OBS_RIGHT: c[0] = -u;
            OBS_LAND:  r.land = 1'b1;
            default:   ;
        endcase

        r.roll    = c[0][DATA_WIDTH-1:0];
        r.pitch   = c[1][DATA_WIDTH-1:0];
        r.climb   = c[2][DATA_WIDTH-1:0];
        r.turn    = c[3][DATA_WIDTH-1:0];
        r.settled = hit;
        return r;
    endfunction

    task automatic report(input string what, input longint got, input longint want);
        errors++;
        if (errors <= 50)
            $display("%0t: mismatch on %s, got %0d expected %0d", $time, what, got, want);
    endtask

    task automatic check_beat(input command_t want);
        if (cmd.cmd_roll !== want.roll)
            report("cmd_roll", cmd.cmd_roll, want.roll);
        if (cmd.cmd_pitch !== want.pitch)
            report("cmd_pitch", cmd.cmd_pitch, want.pitch);
        if (cmd.cmd_climb !== want.climb)
            report("cmd_climb", cmd.cmd_climb, want.climb);
        if (cmd.cmd_turn !== want.turn)
            report("cmd_turn", cmd.cmd_turn, want.turn);
        if (cmd.advance !== want.advance)
            report("advance", cmd.advance, want.advance);
        if (cmd.land_request !== want.land)
            report("land_request", cmd.land_request, want.land);
        if (cmd.settled !== want.settled)
            report("settled", cmd.settled, want.settled);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        longint meas [4];
        longint vel [4];
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
                gains[i] = '0;
            unit_step      = '0;
            goal_radius    = '0;
            target_alt     = DATA_WIDTH'(ALT_RESET);
            target_heading = '0;
            settle_latch   = 1'b0;
            settle_count   = '0;
            errors         = 0;
            commands_due.delete();
        end
        else
        begin
            // a result always trails its own tick, so the beat is checked before the tick is queued
            if (cmd.valid && cmd.ready)
            begin
                if (commands_due.size() == 0)
                    report("beat with nothing pending, cmd_roll", cmd.cmd_roll, 0);
                else
                    check_beat(commands_due.pop_front());
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_GAINS_X, REG_GAINS_Y, REG_GAINS_Z, REG_GAINS_YAW:
                        gains[cfg_index[1:0]] = cfg_data;
                    REG_UNIT_STEP:       unit_step      = cfg_data[DATA_WIDTH-2:0];
                    REG_GOAL_RADIUS:     goal_radius    = cfg_data[DATA_WIDTH-2:0];
                    REG_TARGET_ALTITUDE: target_alt     = cfg_data[DATA_WIDTH-1:0];
                    REG_TARGET_HEADING:  target_heading = cfg_data[DATA_WIDTH-1:0];
                    default: ;
                endcase
            end
            if (tick.valid && tick.ready)
            begin
                meas[0] = tick.pos_x;
                meas[1] = tick.pos_y;
                meas[2] = tick.pos_z;
                meas[3] = tick.heading;
                vel[0]  = tick.vel_x;
                vel[1]  = tick.vel_y;
                vel[2]  = tick.vel_z;
                vel[3]  = tick.vel_heading;
                commands_due.insert(commands_due.size(),
                                    compute_command(meas, vel, tick.goal_x, tick.goal_y,
                                                    tick.obstacle_code, tick.link_lost));
            end
        end
        pending = commands_due.size();
    end

endmodule

[dv/waypoint_pd_command_step_test.sv]
// testbench top for the waypoint pd command step: stimulus, flow control and verdict
`timescale 1ns / 100ps

module waypoint_pd_command_step_test;
    import wpc_pkg::*;

    localparam int SET_MAX    = 0;
    localparam int SET_MIN    = 1;
    localparam int SET_RANDOM = 2;
    localparam int PHASES     = 9;
    localparam int PHASE_TICKS = 150;

    typedef struct packed {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic signed [15:0] heading;
        logic signed [15:0] vel_x;
        logic signed [15:0] vel_y;
        logic signed [15:0] vel_z;
        logic signed [15:0] vel_heading;
        logic signed [15:0] goal_x;
        logic signed [15:0] goal_y;
        logic [OBS_W-1:0]   code;
        logic               lost;
    } tick_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_we = 1'b0;
    logic [IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;
    int               chk_errors;
    int               chk_pending;
    int               feed_idle_pct = 0;
    int               drain_stall_pct = 0;

    // setpoints as last written, so that flight legs hover near them
    logic signed [15:0] alt_sp = 16'sd1229;
    logic signed [15:0] heading_sp = '0;

    // current approach leg toward a waypoint
    int leg_left = 0;
    int leg_len;
    int leg_gx;
    int leg_gy;
    int leg_ox;
    int leg_oy;
    int leg_miss_x;
    int leg_miss_y;

    wpc_in_if  #(.DW(16)) tick ();
    wpc_out_if #(.DW(16)) cmd ();

    waypoint_pd_command_step u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .tick      (tick),
        .cmd       (cmd)
    );

    waypoint_pd_command_step_checker u_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .tick      (tick),
        .cmd       (cmd),
        .errors    (chk_errors),
        .pending   (chk_pending)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("waypoint_pd_command_step_test: FAIL");
        $finish;
    end

    // receiver: holds ready low in stall bursts of random length
    initial
    begin
        cmd.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (drain_stall_pct != 0 && $urandom_range(0, 99) < drain_stall_pct)
            begin
                cmd.ready = 1'b0;
                repeat ($urandom_range(0, 11)) @(negedge clk);
            end
            else
                cmd.ready = 1'b1;
        end
    end

    function automatic int spread(input int lim);
        return int'($urandom_range(0, 2 * lim)) - lim;
    endfunction

    function automatic tick_t noise_tick();
        tick_t t;
        t = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), 4'($urandom())};
        return t;
    endfunction

    // walks toward the waypoint, ending on it or just off it
    function automatic tick_t flight_tick();
        tick_t t;
        int    rem;
        if (leg_left == 0)
        begin
            leg_len    = $urandom_range(4, 40);
            leg_left   = leg_len;
            leg_gx     = spread(8192);
            leg_gy     = spread(8192);
            leg_ox     = spread(16384);
            leg_oy     = spread(16384);
            leg_miss_x = ($urandom_range(0, 99) < 70) ? 0 : spread(800);
            leg_miss_y = ($urandom_range(0, 99) < 70) ? 0 : spread(800);
        end
        leg_left--;
        rem = leg_left;
        t.goal_x      = 16'(leg_gx);
        t.goal_y      = 16'(leg_gy);
        t.pos_x       = 16'(leg_gx - leg_ox * rem / leg_len - leg_miss_x);
        t.pos_y       = 16'(leg_gy - leg_oy * rem / leg_len - leg_miss_y);
        t.pos_z       = 16'(int'(alt_sp) + spread(1024));
        t.heading     = 16'(int'(heading_sp) + spread(600));
        t.vel_x       = 16'(leg_ox / leg_len + spread(512));
        t.vel_y       = 16'(leg_oy / leg_len + spread(512));
        t.vel_z       = 16'(spread(512));
        t.vel_heading = 16'(spread(300));
        t.code        = ($urandom_range(0, 99) < 85) ? OBS_CLEAR : OBS_W'($urandom_range(1, 7));
        t.lost        = ($urandom_range(0, 99) < 3);
        return t;
    endfunction

    task automatic send_tick(input tick_t t);
        @(negedge clk);
        if (feed_idle_pct != 0 && $urandom_range(0, 99) < feed_idle_pct)
        begin
            tick.valid = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
        tick.pos_x         = t.pos_x;
        tick.pos_y         = t.pos_y;
        tick.pos_z         = t.pos_z;
        tick.heading       = t.heading;
        tick.vel_x         = t.vel_x;
        tick.vel_y         = t.vel_y;
        tick.vel_z         = t.vel_z;
        tick.vel_heading   = t.vel_heading;
        tick.goal_x        = t.goal_x;
        tick.goal_y        = t.goal_y;
        tick.obstacle_code = t.code;
        tick.link_lost     = t.lost;
        tick.valid         = 1'b1;
        do
            @(posedge clk);
        while (tick.ready !== 1'b1);
    endtask

    // every beat back, then the block's own latency before touching registers
    task automatic wait_idle();
        @(negedge clk);
        tick.valid = 1'b0;
        while (chk_pending != 0)
            @(negedge clk);
        repeat (30) @(negedge clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    task automatic load_settings(input int style);
        logic [31:0]        g [4];
        logic [14:0]        unit;
        logic [14:0]        radius;
        logic signed [15:0] alt;
        logic signed [15:0] hdg;
        case (style)
            SET_MAX:
            begin
                g      = '{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff};
                unit   = 15'h7fff;
                radius = 15'h7fff;
                alt    = 16'sh7fff;
                hdg    = 16'sh8000;
            end
            SET_MIN:
            begin
                g      = '{32'h0, 32'h0, 32'h0, 32'h0};
                unit   = '0;
                radius = '0;
                alt    = 16'sh8000;
                hdg    = 16'sh7fff;
            end
            default:
            begin
                for (int i = 0; i < 4; i++)
                    g[i] = ($urandom_range(0, 3) == 0) ? 32'h0 : $urandom();
                unit   = 15'($urandom());
                radius = ($urandom_range(0, 3) == 0) ? 15'd0 : 15'($urandom_range(0, 1500));
                alt    = 16'($urandom());
                hdg    = 16'($urandom());
            end
        endcase
        write_reg(REG_GAINS_X, g[0]);
        write_reg(REG_GAINS_Y, g[1]);
        write_reg(REG_GAINS_Z, g[2]);
        write_reg(REG_GAINS_YAW, g[3]);
        // junk above each register's width must be dropped
        write_reg(REG_UNIT_STEP, {17'($urandom()), unit});
        write_reg(REG_GOAL_RADIUS, {17'($urandom()), radius});
        write_reg(REG_TARGET_ALTITUDE, {16'($urandom()), alt});
        write_reg(REG_TARGET_HEADING, {16'($urandom()), hdg});
        alt_sp     = alt;
        heading_sp = hdg;
    endtask

    task automatic directed_ticks();
        tick_t t;
        int    yaw_err [4];
        yaw_err = '{178, 179, -179, -178};

        // reset defaults: no gains, zero unit step
        t = '0;
        send_tick(t);
        t = {{10{16'h7fff}}, OBS_CLEAR, 1'b0};
        send_tick(t);
        t = {{10{16'h8000}}, OBS_CLEAR, 1'b0};
        send_tick(t);
        wait_idle();

        // only x has gain: largest term is zero, negative x term saturates
        write_reg(REG_GAINS_X, 32'h0100_0100);
        write_reg(REG_UNIT_STEP, 32'd1024);
        t = '0;
        t.pos_x = 16'sd1000;
        send_tick(t);
        wait_idle();

        write_reg(REG_GAINS_X, 32'h0200_0080);
        write_reg(REG_GAINS_Y, 32'h0200_0080);
        write_reg(REG_GAINS_Z, 32'h0200_0080);
        write_reg(REG_GAINS_YAW, 32'h0200_0080);
        write_reg(REG_TARGET_ALTITUDE, 32'd0);
        alt_sp = '0;
        for (int i = 0; i < 8; i++)
        begin
            t = '0;
            t.pos_x  = 16'($urandom_range(0, 4000));
            t.goal_y = 16'($urandom_range(0, 4000));
            t.code   = OBS_W'(i);
            send_tick(t);
        end
        t = '0;
        t.pos_y = 16'sd2000;
        t.lost  = 1'b1;
        send_tick(t);
        // either side of the yaw deadband
        for (int i = 0; i < 4; i++)
        begin
            t = '0;
            t.pos_x   = 16'sd300;
            t.heading = 16'(-yaw_err[i]);
            send_tick(t);
        end
        t = '0;
        t.pos_x       = 16'sh7fff;
        t.goal_x      = 16'sh8000;
        t.vel_x       = 16'sh8000;
        t.vel_heading = 16'sh7fff;
        send_tick(t);
        t = '0;
        t.pos_z  = 16'sh7fff;
        t.vel_z  = 16'sh8000;
        t.pos_y  = 16'sh8000;
        t.goal_y = 16'sh7fff;
        send_tick(t);
        wait_idle();

        // on the waypoint with the widest radius: sets the latch
        write_reg(REG_GOAL_RADIUS, 32'h7fff);
        t = '0;
        t.pos_x  = 16'sd5;
        t.goal_x = 16'sd5;
        send_tick(t);
        wait_idle();
    endtask

    initial
    begin
        tick.valid         = 1'b0;
        tick.pos_x         = '0;
        tick.pos_y         = '0;
        tick.pos_z         = '0;
        tick.heading       = '0;
        tick.vel_x         = '0;
        tick.vel_y         = '0;
        tick.vel_z         = '0;
        tick.vel_heading   = '0;
        tick.goal_x        = '0;
        tick.goal_y        = '0;
        tick.obstacle_code = OBS_CLEAR;
        tick.link_lost     = 1'b0;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        directed_ticks();

        for (int p = 0; p < PHASES; p++)
        begin
            load_settings(p == 0 ? SET_MAX : (p == 1 ? SET_MIN : SET_RANDOM));
            if (p == PHASES - 1)
            begin
                feed_idle_pct   = 0;
                drain_stall_pct = 0;
            end
            else
            begin
                feed_idle_pct   = (p % 3) * 12;
                drain_stall_pct = ((p + 1) % 3) * 12;
            end
            repeat (PHASE_TICKS)
            begin
                if ($urandom_range(0, 99) < 80)
                    send_tick(flight_tick());
                else
                    send_tick(noise_tick());
            end
            wait_idle();
        end

        if (chk_errors == 0)
            $display("waypoint_pd_command_step_test: PASS");
        else
            $display("waypoint_pd_command_step_test: FAIL");
        $finish;
    end

endmodule
